>>> src/assert_macros.svh
// assertion macros used by the frame core of the frame parser rtl
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> src/fmp_pkg.sv
// shared types and constants for the framed message parser
// no dependencies
package fmp_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_MAGIC   = 3'd0;
  localparam logic [2:0] CFG_VERSION = 3'd1;
  localparam logic [2:0] CFG_MAX_CH  = 3'd2;
  localparam logic [2:0] CFG_MAX_LEN = 3'd3;
  // highest index, no register behind it
  localparam logic [2:0] CFG_SPARE   = 3'd7;

  // configuration reset values
  localparam logic [15:0] RST_MAGIC   = 16'hCAFE;
  localparam logic [7:0]  RST_VERSION = 8'd1;
  localparam logic [15:0] RST_MAX_CH  = 16'd1023;
  localparam logic [8:0]  RST_MAX_LEN = 9'd256;

  // frame geometry
  localparam logic [16:0] HDR_BYTES = 17'd8;
  localparam logic [16:0] POS_MAX   = 17'h1FFFF;
  localparam logic [7:0]  TYPE_LOW  = 8'd1;
  localparam logic [7:0]  TYPE_HIGH = 8'd4;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame status codes
  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_SHORT   = 4'd1;
  localparam logic [3:0] ST_MAGIC   = 4'd2;
  localparam logic [3:0] ST_VERSION = 4'd3;
  localparam logic [3:0] ST_TYPE    = 4'd4;
  localparam logic [3:0] ST_CHANNEL = 4'd5;
  localparam logic [3:0] ST_LENGTH  = 4'd6;
  localparam logic [3:0] ST_TRUNC   = 4'd7;
  localparam logic [3:0] ST_CKSUM   = 4'd8;

  typedef struct packed {
    logic [15:0] magic;
    logic [7:0]  version;
    logic [15:0] max_channel;
    logic [8:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pl_byte;
    logic [7:0]  pl_index;
    logic [3:0]  status;
    logic [7:0]  version;
    logic [7:0]  mtype;
    logic [15:0] channel;
    logic [15:0] length;
  } result_t;

endpackage

>>> src/fmp_cfg_regs.sv
// configuration registers of the framed message parser
// depends on fmp_pkg
module fmp_cfg_regs import fmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        cfg_ready_o,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // register write decode, unknown indexes dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAGIC:   cfg_d.magic       = cfg_data_i;
        CFG_VERSION: cfg_d.version     = cfg_data_i[7:0];
        CFG_MAX_CH:  cfg_d.max_channel = cfg_data_i;
        CFG_MAX_LEN: cfg_d.max_len     = cfg_data_i[8:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic       <= RST_MAGIC;
      cfg_q.version     <= RST_VERSION;
      cfg_q.max_channel <= RST_MAX_CH;
      cfg_q.max_len     <= RST_MAX_LEN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/fmp_frame_core.sv
// frame state and per-byte decode: header capture, checksum, result build
// depends on fmp_pkg and assert_macros.svh
`include "assert_macros.svh"

module fmp_frame_core import fmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [16:0] pos_q, pos_d;
  logic [15:0] magic_q, magic_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  typ_q, typ_d;
  logic [15:0] chan_q, chan_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic        seen_q, seen_d;
  logic        match_q, match_d;

  logic [15:0] magic_n, chan_n, len_n;
  logic [7:0]  ver_n, typ_n;
  logic        seen_n, match_n;
  logic [16:0] ck_pos;
  logic        in_hdr, before_ck, at_ck, emit_pl;
  logic [3:0]  hdr_st, end_st;

  // header capture by byte position
  assign in_hdr = (pos_q < HDR_BYTES);
  always_comb begin
    magic_n = magic_q;
    ver_n   = ver_q;
    typ_n   = typ_q;
    chan_n  = chan_q;
    len_n   = len_q;
    if (in_hdr) begin
      case (pos_q[2:0])
        3'd0:    magic_n = {byte_i, 8'h00};
        3'd1:    magic_n = {magic_q[15:8], byte_i};
        3'd2:    ver_n   = byte_i;
        3'd3:    typ_n   = byte_i;
        3'd4:    chan_n  = {byte_i, 8'h00};
        3'd5:    chan_n  = {chan_q[15:8], byte_i};
        3'd6:    len_n   = {byte_i, 8'h00};
        default: len_n   = {len_q[15:8], byte_i};
      endcase
    end
  end

  // checksum byte sits right after the payload
  assign ck_pos    = HDR_BYTES + {1'b0, len_q};
  assign before_ck = (pos_q < ck_pos);
  assign at_ck     = !in_hdr && (pos_q == ck_pos) && !seen_q;
  assign seen_n    = seen_q | at_ck;
  assign match_n   = at_ck ? (byte_i == sum_q) : match_q;

  // header checks in field order
  always_comb begin
    if (magic_q != cfg_i.magic)                           hdr_st = ST_MAGIC;
    else if (ver_q != cfg_i.version)                      hdr_st = ST_VERSION;
    else if ((typ_q < TYPE_LOW) || (typ_q > TYPE_HIGH))   hdr_st = ST_TYPE;
    else if (chan_q > cfg_i.max_channel)                  hdr_st = ST_CHANNEL;
    else if (len_q > {7'd0, cfg_i.max_len})               hdr_st = ST_LENGTH;
    else                                                  hdr_st = ST_OK;
  end

  // end of buffer status
  always_comb begin
    if (in_hdr)             end_st = ST_SHORT;
    else if (hdr_st != ST_OK) end_st = hdr_st;
    else if (!seen_n)       end_st = ST_TRUNC;
    else if (!match_n)      end_st = ST_CKSUM;
    else                    end_st = ST_OK;
  end

  assign emit_pl = !last_i && !in_hdr && before_ck && (hdr_st == ST_OK);

  // result item
  always_comb begin
    res_o.kind     = last_i ? KIND_STATUS : KIND_PAYLOAD;
    res_o.pl_byte  = last_i ? 8'h00 : byte_i;
    res_o.pl_index = last_i ? 8'h00 : (pos_q[7:0] - HDR_BYTES[7:0]);
    res_o.status   = last_i ? end_st : ST_OK;
    res_o.version  = ver_n;
    res_o.mtype    = typ_n;
    res_o.channel  = chan_n;
    res_o.length   = len_n;
  end
  assign res_valid_o = fire_i && (last_i || emit_pl);

  // state update, whole frame cleared after its last byte
  always_comb begin
    pos_d   = pos_q;
    magic_d = magic_q;
    ver_d   = ver_q;
    typ_d   = typ_q;
    chan_d  = chan_q;
    len_d   = len_q;
    sum_d   = sum_q;
    seen_d  = seen_q;
    match_d = match_q;
    if (fire_i) begin
      if (last_i) begin
        pos_d   = '0;
        magic_d = '0;
        ver_d   = '0;
        typ_d   = '0;
        chan_d  = '0;
        len_d   = '0;
        sum_d   = '0;
        seen_d  = 1'b0;
        match_d = 1'b0;
      end else begin
        pos_d   = (pos_q != POS_MAX) ? pos_q + 17'd1 : pos_q;
        magic_d = magic_n;
        ver_d   = ver_n;
        typ_d   = typ_n;
        chan_d  = chan_n;
        len_d   = len_n;
        sum_d   = before_ck ? sum_q + byte_i : sum_q;
        seen_d  = seen_n;
        match_d = match_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      magic_q <= '0;
      ver_q   <= '0;
      typ_q   <= '0;
      chan_q  <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      seen_q  <= 1'b0;
      match_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      magic_q <= magic_d;
      ver_q   <= ver_d;
      typ_q   <= typ_d;
      chan_q  <= chan_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      seen_q  <= seen_d;
      match_q <= match_d;
    end
  end

  `ASSERT_AT(a_clear_after_last, clk_i, rst_ni, fire_i && last_i |=> pos_q == '0, "frame state not cleared after last byte")
  `ASSERT_AT(a_seen_past_header, clk_i, rst_ni, seen_q |-> pos_q > HDR_BYTES, "checksum seen inside header")
  `ASSERT_NEVER(a_payload_bad_hdr, clk_i, rst_ni, res_valid_o && (res_o.kind == KIND_PAYLOAD) && (hdr_st != ST_OK || in_hdr), "payload item from invalid header")

endmodule

>>> src/fmp_out_stage.sv
// result register of the framed message parser
// depends on fmp_pkg
module fmp_out_stage import fmp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // free when empty or being taken this cycle
  assign can_load_o = !valid_q || !out_stall_i;

  always_comb begin
    if (load_i)           valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
    else                  valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> src/framed_message_parser_unit.sv
// top level of the framed message parser: input register, core, result register
// depends on fmp_pkg, fmp_cfg_regs, fmp_frame_core, fmp_out_stage
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   data_byte_i, last_byte_i
//  out      output     out_valid_o / out_stall_i item_kind_o .. frame_length_o
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one byte per cycle sustained while out_stall_i is low; a byte passes the
// input register, then is decoded into the result register
// a byte leaves the input register only while the result register is free
// reset clears configuration to defaults and the frame state to empty
// a stalled result holds the result register; the input register then fills
// and in_stall_o rises
module framed_message_parser_unit import fmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic [3:0]  frame_status_o,
  output logic [7:0]  frame_version_o,
  output logic [7:0]  frame_type_o,
  output logic [15:0] frame_channel_o,
  output logic [15:0] frame_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t    cfg;
  result_t core_res, out_res;
  logic    core_valid, can_load, s1_adv, in_fire;
  logic    s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic    s1_last_q;

  fmp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  // input register handshake
  assign s1_adv     = s1_valid_q && can_load;
  assign in_stall_o = s1_valid_q && !can_load;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_fire)     s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
    else             s1_valid_d = s1_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  fmp_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_adv),
    .byte_i      (s1_byte_q),
    .last_i      (s1_last_q),
    .cfg_i       (cfg),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  fmp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (core_valid),
    .res_i       (core_res),
    .out_stall_i (out_stall_i),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  // result fields to ports
  assign item_kind_o     = out_res.kind;
  assign payload_byte_o  = out_res.pl_byte;
  assign payload_index_o = out_res.pl_index;
  assign frame_status_o  = out_res.status;
  assign frame_version_o = out_res.version;
  assign frame_type_o    = out_res.mtype;
  assign frame_channel_o = out_res.channel;
  assign frame_length_o  = out_res.length;

endmodule
